>>> hw/rtl/gra_pkg.sv
package gra_pkg;

    // Default sizing, overridable from the top level
    localparam int MAX_FREE_DEF   = 64;
    localparam int COORD_BITS_DEF = 16;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_BIN_WIDTH  = 2'd0,
        CFG_BIN_HEIGHT = 2'd1,
        CFG_ROT_ENABLE = 2'd2
    } t_cfg_idx;

    // Request operation codes
    typedef enum logic {
        OP_START = 1'b0,
        OP_PLACE = 1'b1
    } t_op;

    // Input beat
    typedef struct packed {
        t_op         operation;
        logic [15:0] rect_width;
        logic [15:0] rect_height;
    } t_in_item;

    // Result beat
    typedef struct packed {
        logic        placed;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic        rotated;
        logic        space_dropped;
    } t_out_item;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_SHIFT,
        ST_PUSH_R,
        ST_PUSH_B,
        ST_DONE
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic start;
        logic walk;
        logic capture;
        logic rotate;
        logic shift_wr;
        logic push_right;
        logic push_bottom;
        logic emit;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic hit;
        logic walk_end;
        logic rot_enable;
        logic rotated;
        logic out_blocked;
    } t_dp_status;

endpackage

>>> hw/rtl/guillotine_rect_allocator_core.sv
// Guillotine first-fit rectangle allocator.
// Input channel (i_in_valid / o_in_stall / i_in_data): one beat per request,
// either start a new bin or place a rectangle. Output channel (o_out_valid /
// i_out_stall / o_out_data): exactly one result beat per request, in order.
// Configuration channel (i_cfg_valid / o_cfg_ready, always ready): bin width,
// bin height and the rotation enable; write only while no request is open.
// One request is in work at a time. A start writes the whole bin as the only
// list entry, then loads the result register. A place walks the free list
// through the single read port of the list memory, one entry a cycle: a scan
// pass, then, on a hit, moving each entry behind the chosen one up by one place
// to close the gap, then appending the remainders and loading the result. With
// rotation enabled, a place that fits nowhere unrotated makes a second, rotated
// scan pass. The next request is accepted from the cycle after the result is
// loaded, while that result may still wait downstream; a stalled result holds
// and blocks only the loading of the next one. Reset empties the list, so a
// place before any start fails, and restores the configuration defaults. The
// list memory needs no clearing.
module guillotine_rect_allocator_core
    import gra_pkg::*;
#(
    parameter int MAX_FREE   = MAX_FREE_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data
);

    t_dp_cmd    cmd;
    t_dp_status status;

    assign o_cfg_ready = 1'b1;

    gra_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_op    (i_in_data.operation),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    gra_dpath #(
        .MAX_FREE   (MAX_FREE),
        .COORD_BITS (COORD_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (cmd),
        .o_status    (status)
    );

endmodule

>>> hw/rtl/gra_ram.sv
module gra_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write one entry, read one entry with registered data
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hw/rtl/gra_ctrl.sv
module gra_ctrl
    import gra_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_op        i_in_op,
    output logic       o_in_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequence one request at a time
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = (i_in_op == OP_START) ? ST_START : ST_SCAN;
                end
            end
            ST_START: begin
                o_cmd.start = 1'b1;
                n_state     = ST_DONE;
            end
            ST_SCAN: begin
                if (i_status.hit) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_SHIFT;
                end else if (i_status.walk_end) begin
                    if (i_status.rot_enable && !i_status.rotated) begin
                        o_cmd.rotate = 1'b1;
                    end else begin
                        n_state = ST_DONE;
                    end
                end else begin
                    o_cmd.walk = 1'b1;
                end
            end
            ST_SHIFT: begin
                o_cmd.walk     = 1'b1;
                o_cmd.shift_wr = 1'b1;
                if (i_status.walk_end) begin
                    n_state = ST_PUSH_R;
                end
            end
            ST_PUSH_R: begin
                o_cmd.push_right = 1'b1;
                n_state          = ST_PUSH_B;
            end
            ST_PUSH_B: begin
                o_cmd.push_bottom = 1'b1;
                n_state           = ST_DONE;
            end
            ST_DONE: begin
                if (!i_status.out_blocked) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

>>> hw/rtl/gra_dpath.sv
module gra_dpath
    import gra_pkg::*;
#(
    parameter int MAX_FREE   = MAX_FREE_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  t_in_item    i_in_data,
    input  logic        i_out_stall,
    output logic        o_out_valid,
    output t_out_item   o_out_data,
    input  t_dp_cmd     i_cmd,
    output t_dp_status  o_status
);

    localparam int ADDR_W = $clog2(MAX_FREE);
    localparam int CNT_W  = $clog2(MAX_FREE + 1);
    localparam int CB     = COORD_BITS;
    localparam int ENT_W  = 4 * COORD_BITS;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FREE);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    // Configuration
    logic [15:0] r_bin_w;
    logic [15:0] r_bin_h;
    logic        r_allow_rot;

    // Request and walk state
    logic [CB-1:0]    r_wp;
    logic [CB-1:0]    r_hp;
    logic             r_rot;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_idx;
    logic [CNT_W-1:0] r_chk_idx;
    logic             r_pend;

    // Chosen free rectangle and result flags
    logic [CB-1:0] r_fx;
    logic [CB-1:0] r_fy;
    logic [CB-1:0] r_fw;
    logic [CB-1:0] r_fh;
    logic          r_placed;
    logic          r_drop;

    // Result register
    logic      r_out_valid;
    t_out_item r_out;

    // Memory port signals
    logic             wr_en;
    logic [CNT_W-1:0] wr_idx;
    logic [ENT_W-1:0] wr_data;
    logic [ENT_W-1:0] rd_data;
    logic [CB-1:0]    rd_left;
    logic [CB-1:0]    rd_top;
    logic [CB-1:0]    rd_wide;
    logic [CB-1:0]    rd_tall;
    logic             fits;
    logic             right_nz;
    logic             bottom_nz;
    logic             room;
    logic             idx_live;

    gra_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_FREE)
    ) u_free_list (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_idx[ADDR_W-1:0]),
        .i_wr_data (wr_data),
        .i_rd_addr (r_idx[ADDR_W-1:0]),
        .o_rd_data (rd_data)
    );

    // Unpack the entry read last cycle and test it
    assign rd_left   = rd_data[4*CB-1:3*CB];
    assign rd_top    = rd_data[3*CB-1:2*CB];
    assign rd_wide   = rd_data[2*CB-1:CB];
    assign rd_tall   = rd_data[CB-1:0];
    assign fits      = (r_wp <= rd_wide) && (r_hp <= rd_tall);
    assign right_nz  = (r_fw != r_wp);
    assign bottom_nz = (r_fh != r_hp);
    assign room      = (r_count < CNT_MAX);
    assign idx_live  = (r_idx < r_count);

    assign o_status.hit         = r_pend && fits;
    assign o_status.walk_end    = !r_pend && !idx_live;
    assign o_status.rot_enable  = r_allow_rot;
    assign o_status.rotated     = r_rot;
    assign o_status.out_blocked = r_out_valid && i_out_stall;

    // Select the memory write: bin start, compaction move or remainder append
    always_comb begin
        wr_en   = 1'b0;
        wr_idx  = '0;
        wr_data = '0;
        if (i_cmd.start) begin
            wr_en   = 1'b1;
            wr_data = {{CB{1'b0}}, {CB{1'b0}}, CB'(r_bin_w), CB'(r_bin_h)};
        end else if (i_cmd.shift_wr && r_pend) begin
            wr_en   = 1'b1;
            wr_idx  = r_chk_idx - CNT_ONE;
            wr_data = rd_data;
        end else if (i_cmd.push_right && right_nz) begin
            wr_en   = 1'b1;
            wr_idx  = r_count - CNT_ONE;
            wr_data = {CB'(r_fx + r_wp), r_fy, CB'(r_fw - r_wp), r_fh};
        end else if (i_cmd.push_bottom && bottom_nz && room) begin
            wr_en   = 1'b1;
            wr_idx  = r_count;
            wr_data = {r_fx, CB'(r_fy + r_hp), r_wp, CB'(r_fh - r_hp)};
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_w     <= 16'd1024;
            r_bin_h     <= 16'd1024;
            r_allow_rot <= 1'b0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_BIN_WIDTH:  r_bin_w     <= i_cfg_data;
                CFG_BIN_HEIGHT: r_bin_h     <= i_cfg_data;
                CFG_ROT_ENABLE: r_allow_rot <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // List count and pending-read flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            if (i_cmd.load || i_cmd.capture || i_cmd.rotate) begin
                r_pend <= 1'b0;
            end else if (i_cmd.walk) begin
                r_pend <= idx_live;
            end
            if (i_cmd.start) begin
                r_count <= CNT_ONE;
            end else if (i_cmd.push_right) begin
                r_count <= right_nz ? r_count : r_count - CNT_ONE;
            end else if (i_cmd.push_bottom && bottom_nz && room) begin
                r_count <= r_count + CNT_ONE;
            end
        end
    end

    // Request, walk index and chosen rectangle
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_wp     <= CB'(i_in_data.rect_width);
            r_hp     <= CB'(i_in_data.rect_height);
            r_rot    <= 1'b0;
            r_placed <= 1'b0;
            r_drop   <= 1'b0;
            r_idx    <= '0;
        end else if (i_cmd.capture) begin
            r_fx      <= rd_left;
            r_fy      <= rd_top;
            r_fw      <= rd_wide;
            r_fh      <= rd_tall;
            r_placed  <= 1'b1;
            r_idx     <= r_chk_idx + CNT_ONE;
        end else if (i_cmd.rotate) begin
            r_wp  <= r_hp;
            r_hp  <= r_wp;
            r_rot <= 1'b1;
            r_idx <= '0;
        end else if (i_cmd.walk && idx_live) begin
            r_chk_idx <= r_idx;
            r_idx     <= r_idx + CNT_ONE;
        end
        if (i_cmd.push_bottom && bottom_nz && !room) begin
            r_drop <= 1'b1;
        end
    end

    // Result register: fill on emit, drain when the receiver takes the beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.placed        <= r_placed;
            r_out.pos_x         <= r_placed ? 16'(r_fx) : 16'd0;
            r_out.pos_y         <= r_placed ? 16'(r_fy) : 16'd0;
            r_out.rotated       <= r_placed && r_rot;
            r_out.space_dropped <= r_placed && r_drop;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The list never holds more than its capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("free list count beyond capacity");

    // Every write lands inside the list memory
    a_write_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (wr_idx < CNT_MAX))
        else $error("free list write outside memory");

    // A dropped remainder is only reported with a placement
    a_drop_placed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (!r_out.space_dropped || r_out.placed))
        else $error("space_dropped without placed");

endmodule

>>> dv/tb_guillotine_rect_allocator_core.sv
module tb_guillotine_rect_allocator_core;
    import gra_pkg::*;

    localparam int        LIST_DEPTH   = MAX_FREE_DEF;
    localparam int        STALL_LIMIT  = 4000;
    localparam int        PHASE_ITEMS  = 55;
    localparam int        PHASE_COUNT  = 8;
    localparam logic [1:0] CFG_SPARE   = 2'd3;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data  = '0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_data   = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_data;

    guillotine_rect_allocator_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // Shadow copy of the allocator: configuration and free list
    logic [15:0] bin_w  = 16'd1024;
    logic [15:0] bin_h  = 16'd1024;
    logic        rot_en = 1'b0;
    logic [15:0] free_x [LIST_DEPTH];
    logic [15:0] free_y [LIST_DEPTH];
    logic [15:0] free_w [LIST_DEPTH];
    logic [15:0] free_h [LIST_DEPTH];
    int          free_n = 0;

    t_in_item  request_q[$];
    t_out_item placement_q[$];
    int        idle_pct      = 0;
    int        stall_pct     = 0;
    int        mismatch_count = 0;
    int        quiet_cycles  = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // First free entry that holds w by h, or -1
    function automatic int find_fit(logic [15:0] w, logic [15:0] h);
        for (int i = 0; i < free_n; i++) begin
            if (w <= free_w[i] && h <= free_h[i]) return i;
        end
        return -1;
    endfunction

    function automatic void push_free(logic [15:0] x, logic [15:0] y,
                                      logic [15:0] w, logic [15:0] h);
        if (free_n >= LIST_DEPTH) return;
        free_x[free_n] = x;
        free_y[free_n] = y;
        free_w[free_n] = w;
        free_h[free_n] = h;
        free_n++;
    endfunction

    // Apply one request to the shadow list and return the placement it yields
    function automatic t_out_item allocate_rect(t_in_item req);
        t_out_item   res;
        logic [15:0] wp, hp, fx, fy, fw, fh;
        int          hit;
        res = '0;
        if (req.operation == OP_START) begin
            free_n = 0;
            push_free(16'd0, 16'd0, bin_w, bin_h);
            return res;
        end
        wp  = req.rect_width;
        hp  = req.rect_height;
        hit = find_fit(wp, hp);
        if (hit < 0 && rot_en) begin
            wp  = req.rect_height;
            hp  = req.rect_width;
            res.rotated = 1'b1;
            hit = find_fit(wp, hp);
        end
        if (hit < 0) return '0;
        fx = free_x[hit];
        fy = free_y[hit];
        fw = free_w[hit];
        fh = free_h[hit];
        // close the gap, keeping the order of the rest
        for (int j = hit; j + 1 < free_n; j++) begin
            free_x[j] = free_x[j + 1];
            free_y[j] = free_y[j + 1];
            free_w[j] = free_w[j + 1];
            free_h[j] = free_h[j + 1];
        end
        free_n--;
        if (fw != wp) push_free(fx + wp, fy, fw - wp, fh);
        if (fh != hp) begin
            if (free_n < LIST_DEPTH) push_free(fx, fy + hp, wp, fh - hp);
            else res.space_dropped = 1'b1;
        end
        res.placed = 1'b1;
        res.pos_x  = fx;
        res.pos_y  = fy;
        return res;
    endfunction

    // Driver: hold a stalled beat, otherwise offer the next request or idle
    always @(posedge i_clk) begin
        t_in_item nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                placement_q = {placement_q, allocate_rect(i_in_data)};
                void'(request_q.pop_front());
            end
            if (!(i_in_valid && o_in_stall)) begin
                if (request_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                    nxt = request_q[0];
                    i_in_valid <= 1'b1;
                    i_in_data  <= nxt;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // Monitor: compare each result beat with the oldest predicted placement
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (placement_q.size() == 0) begin
                    $error("result beat with no request outstanding");
                    mismatch_count++;
                end else begin
                    want = placement_q.pop_front();
                    check_field("placed", want.placed, o_out_data.placed);
                    check_field("pos_x", want.pos_x, o_out_data.pos_x);
                    check_field("pos_y", want.pos_y, o_out_data.pos_y);
                    check_field("rotated", want.rotated, o_out_data.rotated);
                    check_field("space_dropped", want.space_dropped,
                                o_out_data.space_dropped);
                end
            end
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Watchdog: end the run if no beat moves on any channel for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_BIN_WIDTH:  bin_w  = val;
            CFG_BIN_HEIGHT: bin_h  = val;
            CFG_ROT_ENABLE: rot_en = val[0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_bin(int w, int h, int rot);
        write_reg(CFG_BIN_WIDTH, w[15:0]);
        write_reg(CFG_BIN_HEIGHT, h[15:0]);
        write_reg(CFG_ROT_ENABLE, rot[15:0]);
    endtask

    // Wait until every request is accepted and every result has come back
    task automatic wait_drained();
        do @(negedge i_clk);
        while (request_q.size() != 0 || i_in_valid || placement_q.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    function automatic void queue_start();
        t_in_item it;
        it.operation   = OP_START;
        it.rect_width  = 16'($urandom);
        it.rect_height = 16'($urandom);
        request_q = {request_q, it};
    endfunction

    function automatic void queue_place(int w, int h);
        t_in_item it;
        it.operation   = OP_PLACE;
        it.rect_width  = w[15:0];
        it.rect_height = h[15:0];
        request_q = {request_q, it};
    endfunction

    // Mostly sizes well inside the bin, sometimes up to it, rarely anything
    function automatic int pick_size(int span);
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return $urandom_range(1, (span / 4 > 1) ? span / 4 : 1);
        if (r < 9) return $urandom_range(1, span);
        return $urandom_range(1, 65535);
    endfunction

    // Add one sequence; return the number of items queued
    function automatic int add_sequence();
        int kind, n, w, h;
        t_in_item it;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            // noise: any operation, any size
            it.operation   = t_op'($urandom_range(0, 1));
            it.rect_width  = 16'($urandom_range(1, 65535));
            it.rect_height = 16'($urandom_range(1, 65535));
            request_q = {request_q, it};
            return 1;
        end
        if (kind == 1) begin
            // places with no fresh start, sizes unrelated to the bin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
                queue_place($urandom_range(1, 65535), $urandom_range(1, 65535));
            return n;
        end
        queue_start();
        if (kind >= 8) begin
            // many small pieces, aimed at overflowing the free list
            n = $urandom_range(70, 110);
            for (int i = 0; i < n; i++)
                queue_place($urandom_range(1, bin_w < 64 ? bin_w : 64),
                            $urandom_range(1, bin_h < 64 ? bin_h : 64));
        end else begin
            n = $urandom_range(1, 30);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 3) == 0) begin
                    w = pick_size(bin_h);
                    h = pick_size(bin_w);
                end else begin
                    w = pick_size(bin_w);
                    h = pick_size(bin_h);
                end
                queue_place(w, h);
            end
        end
        return n + 1;
    endfunction

    initial begin
        int queued;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);

        // Reset defaults: place before start, exact fits, misses
        queue_place(5, 5);
        queue_start();
        queue_place(100, 200);
        queue_place(924, 1024);
        queue_place(101, 10);
        queue_place(100, 824);
        queue_place(1, 1);
        queue_start();
        queue_place(1024, 1024);
        queue_start();
        queue_place(10, 2000);
        wait_drained();

        // Largest bin with rotation; an unmapped register index is ignored
        set_bin(65535, 65535, 1);
        write_reg(CFG_SPARE, 16'($urandom));
        queue_start();
        queue_place(65535, 65535);
        queue_start();
        queue_place(65535, 1);
        queue_place(1, 65535);
        wait_drained();

        // Rotated fit, then an emptied list
        set_bin(300, 100, 1);
        queue_start();
        queue_place(100, 300);
        queue_place(250, 50);
        wait_drained();

        // Smallest bin
        set_bin(1, 1, 0);
        queue_start();
        queue_place(1, 1);
        queue_place(1, 1);
        wait_drained();

        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0: set_bin(65535, 65535, 1);
                1: set_bin(1, 65535, 1);
                2: set_bin($urandom_range(1, 65535), $urandom_range(1, 65535),
                           $urandom_range(0, 1));
                3: set_bin(65535, 1, 0);
                4: set_bin(1, 1, 1);
                5: set_bin($urandom_range(1024, 65535), $urandom_range(1024, 65535), 1);
                6: set_bin(4096, 2048, 0);
                default: set_bin($urandom_range(1, 65535), $urandom_range(1, 65535),
                                 $urandom_range(0, 1));
            endcase
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 72; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 72; end
                default: begin idle_pct = 23; stall_pct = 23; end
            endcase
            queued = 0;
            while (queued < PHASE_ITEMS) queued += add_sequence();
            wait_drained();
        end

        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && placement_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/gra_pkg.sv
hw/rtl/gra_ram.sv
hw/rtl/gra_ctrl.sv
hw/rtl/gra_dpath.sv
hw/rtl/guillotine_rect_allocator_core.sv
dv/tb_guillotine_rect_allocator_core.sv
